// ===== rtl/pmb_pkg.sv =====
package pmb_pkg;

  // sizing of the two sub-buffers
  localparam int SUB_DEPTH = 1024;
  localparam int CFG_W     = 11;
  localparam int LEN_W     = 8;
  localparam int RCAP_W    = 11;
  localparam int OFF_W     = $clog2(SUB_DEPTH + 1);
  localparam int ADDR_W    = $clog2(2 * SUB_DEPTH);
  localparam int CAP_W     = (OFF_W > CFG_W) ? OFF_W : CFG_W;
  localparam int SUM_W     = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(1024);

  typedef enum logic [1:0] {
    CMD_WRITE_BEGIN,
    CMD_WRITE_BYTE,
    CMD_READ_BEGIN,
    CMD_READ_BYTE
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_SMALL,
    ST_SEQ
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_COMMIT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== rtl/pmb_in_if.sv =====
interface pmb_in_if;
  import pmb_pkg::*;

  logic                    valid;
  logic                    ready;
  cmd_t                    command;
  logic [LEN_W-1:0]        message_length;
  logic [7:0]              data_in;
  logic [RCAP_W-1:0]       reader_capacity;

  modport source (output valid, command, message_length, data_in, reader_capacity,
                  input ready);
  modport sink   (input valid, command, message_length, data_in, reader_capacity,
                  output ready);
endinterface

// ===== rtl/pmb_out_if.sv =====
interface pmb_out_if;
  import pmb_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic [7:0]       data_out;
  logic [LEN_W-1:0] length_out;
  logic             last_byte;

  modport source (output valid, status, data_out, length_out, last_byte, input ready);
  modport sink   (input valid, status, data_out, length_out, last_byte, output ready);
endinterface

// ===== rtl/pmb_ctrl.sv =====
module pmb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output pmb_pkg::ctrl_cmd_t cmd
);
  import pmb_pkg::*;

  state_t state, state_next;
  logic   slot_free;

  // output register can take a word this cycle
  assign slot_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_COMMIT;
      S_COMMIT: if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_LOOKUP: cmd.lookup = 1'b1;
      S_COMMIT: cmd.commit = slot_free;
      default: ;
    endcase
  end

  // state and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("result not presented after commit");
  a_commit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && !slot_free) |=> state == S_COMMIT)
    else $error("commit left while output blocked");
  a_capture_next: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.lookup) else $error("lookup did not follow capture");
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("overlapping datapath commands");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.lookup || state == S_COMMIT) |-> !in_ready)
    else $error("input taken while an item is in flight");
`endif

endmodule

// ===== rtl/pmb_datapath.sv =====
module pmb_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [pmb_pkg::CFG_W-1:0]  cfg_wdata,
  input  pmb_pkg::ctrl_cmd_t         ctl,
  input  pmb_pkg::cmd_t              command,
  input  logic [pmb_pkg::LEN_W-1:0]  message_length,
  input  logic [7:0]                 data_in,
  input  logic [pmb_pkg::RCAP_W-1:0] reader_capacity,
  output pmb_pkg::status_t           status,
  output logic [7:0]                 data_out,
  output logic [pmb_pkg::LEN_W-1:0]  length_out,
  output logic                       last_byte
);
  import pmb_pkg::*;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic side,
                                                 input logic [OFF_W-1:0] off);
    mem_addr = (side ? ADDR_W'(SUB_DEPTH) : ADDR_W'(0)) + ADDR_W'(off);
  endfunction

  // configuration and captured item
  logic [CFG_W-1:0]  cap;
  cmd_t              cmd_q;
  logic [LEN_W-1:0]  mlen_q;
  logic [7:0]        din_q;
  logic [RCAP_W-1:0] rcap_q;

  // buffer bookkeeping
  logic [OFF_W-1:0]  fill_level [2];
  logic              read_side;
  logic [OFF_W-1:0]  read_offset;
  logic [OFF_W-1:0]  write_offset;
  logic [LEN_W-1:0]  write_remaining;
  logic [LEN_W-1:0]  read_remaining;

  // byte store
  logic [7:0]        mem [2*SUB_DEPTH];
  logic [7:0]        mem_q;

  logic              ws, rs;
  logic [OFF_W-1:0]  cap_eff;
  logic              wr_busy, rd_busy, full, rd_empty, too_small, drained, swap;
  logic [OFF_W-1:0]  ro_inc;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata;
  status_t           res_status;
  logic [7:0]        res_dout;
  logic [LEN_W-1:0]  res_lout;
  logic              res_last;

  assign ws = ~read_side;
  assign rs = read_side;

  // effective capacity and decision flags
  assign cap_eff   = (CAP_W'(cap) > CAP_W'(SUB_DEPTH)) ? OFF_W'(SUB_DEPTH) : OFF_W'(cap);
  assign wr_busy   = write_remaining != '0;
  assign rd_busy   = read_remaining != '0;
  assign full      = (SUM_W'(fill_level[ws]) + SUM_W'(mlen_q) + SUM_W'(1)) > SUM_W'(cap_eff);
  assign rd_empty  = read_offset >= fill_level[rs];
  assign too_small = RCAP_W'(mem_q) > rcap_q;
  assign ro_inc    = read_offset + OFF_W'(1);
  assign drained   = ro_inc >= fill_level[rs];
  assign swap      = (cmd_q == CMD_READ_BEGIN) && !rd_busy && rd_empty && !wr_busy;
  assign raddr     = swap ? mem_addr(ws, '0) : mem_addr(rs, read_offset);

  // store write
  always_comb begin
    mem_we = ctl.commit &&
             (((cmd_q == CMD_WRITE_BEGIN) && !wr_busy && !full) ||
              ((cmd_q == CMD_WRITE_BYTE) && wr_busy));
    waddr  = (cmd_q == CMD_WRITE_BEGIN) ? mem_addr(ws, fill_level[ws])
                                        : mem_addr(ws, write_offset);
    wdata  = (cmd_q == CMD_WRITE_BEGIN) ? mlen_q : din_q;
  end

  // result word
  always_comb begin
    res_status = ST_OK;
    res_dout   = '0;
    res_lout   = '0;
    res_last   = 1'b0;
    case (cmd_q)
      CMD_WRITE_BEGIN: begin
        if (wr_busy) res_status = ST_SEQ;
        else if (full) res_status = ST_FULL;
      end
      CMD_WRITE_BYTE: begin
        if (!wr_busy) res_status = ST_SEQ;
      end
      CMD_READ_BEGIN: begin
        if (rd_busy) begin
          res_status = ST_SEQ;
        end else if (rd_empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_lout = mem_q;
          if (too_small) res_status = ST_SMALL;
        end
      end
      CMD_READ_BYTE: begin
        if (!rd_busy) begin
          res_status = ST_SEQ;
        end else begin
          res_dout = mem_q;
          res_last = read_remaining == LEN_W'(1);
        end
      end
      default: res_status = ST_SEQ;
    endcase
  end

  // memory, registered read in the lookup step
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (ctl.lookup) mem_q <= mem[raddr];
  end

  // captured item and result register
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q  <= command;
      mlen_q <= message_length;
      din_q  <= data_in;
      rcap_q <= reader_capacity;
    end
    if (ctl.commit) begin
      status     <= res_status;
      data_out   <= res_dout;
      length_out <= res_lout;
      last_byte  <= res_last;
    end
  end

  // bookkeeping updates
  always_ff @(posedge clk) begin
    if (rst) begin
      cap             <= CAP_RESET;
      fill_level[0]   <= '0;
      fill_level[1]   <= '0;
      read_side       <= 1'b0;
      read_offset     <= '0;
      write_offset    <= '0;
      write_remaining <= '0;
      read_remaining  <= '0;
    end else begin
      if (cfg_wen) cap <= cfg_wdata;
      // drained read side gives way to the write side
      if (ctl.lookup && swap) begin
        fill_level[rs] <= '0;
        read_offset    <= '0;
        read_side      <= ws;
      end
      if (ctl.commit) begin
        case (cmd_q)
          CMD_WRITE_BEGIN: begin
            if (!wr_busy && !full) begin
              write_offset    <= fill_level[ws] + OFF_W'(1);
              write_remaining <= mlen_q;
              if (mlen_q == '0) fill_level[ws] <= fill_level[ws] + OFF_W'(1);
            end
          end
          CMD_WRITE_BYTE: begin
            if (wr_busy) begin
              write_offset    <= write_offset + OFF_W'(1);
              write_remaining <= write_remaining - LEN_W'(1);
              if (write_remaining == LEN_W'(1)) fill_level[ws] <= write_offset + OFF_W'(1);
            end
          end
          CMD_READ_BEGIN: begin
            if (!rd_busy && !rd_empty && !too_small) begin
              read_remaining <= mem_q;
              if (mem_q == '0 && drained) begin
                fill_level[rs] <= '0;
                read_offset    <= '0;
              end else begin
                read_offset    <= ro_inc;
              end
            end
          end
          CMD_READ_BYTE: begin
            if (rd_busy) begin
              read_remaining <= read_remaining - LEN_W'(1);
              if (read_remaining == LEN_W'(1) && drained) begin
                fill_level[rs] <= '0;
                read_offset    <= '0;
              end else begin
                read_offset    <= ro_inc;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/ping_pong_message_buffer.sv =====
// sequence: an accepted word is captured, then looked up in the store, then
//   committed to the result register; commit waits only on a stalled sink
// occupancy: no new word is accepted until capture, store lookup (registered
//   read of the single byte memory) and commit have run for the last one
// reset: clears the controller, fill levels, offsets and transfer counts, and sets
//   the sub-buffer size to 1024; the byte store is not cleared and needs no pass
module ping_pong_message_buffer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [pmb_pkg::CFG_W-1:0] cfg_wdata,
  pmb_in_if.sink                    in_ch,
  pmb_out_if.source                 out_ch
);
  import pmb_pkg::*;

  ctrl_cmd_t cmd;

  // sequencing and handshake
  pmb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // store and bookkeeping
  pmb_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .ctl             (cmd),
    .command         (in_ch.command),
    .message_length  (in_ch.message_length),
    .data_in         (in_ch.data_in),
    .reader_capacity (in_ch.reader_capacity),
    .status          (out_ch.status),
    .data_out        (out_ch.data_out),
    .length_out      (out_ch.length_out),
    .last_byte       (out_ch.last_byte)
  );

endmodule
